// File: rtl/core/cfdp_pkg.sv
// ----------------------------------------------------------------------------
// cfdp_pkg
// Shared types, constants and the month table for the date pair search.
// ----------------------------------------------------------------------------
`default_nettype none

package cfdp_pkg;

	localparam int MAX_DATES_DEF = 64;
	localparam int DN_W          = 23;
	localparam int DIST_W        = 22;
	localparam int PROD_W        = 27;
	localparam int RECIP_SHIFT   = 19;

	localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
	localparam logic [12:0]       RECIP_100  = 13'd5243;
	localparam logic [12:0]       DAYS_YEAR  = 13'd365;
	localparam logic [14:0]       CENTURY    = 15'd100;
	localparam logic [3:0]        MONTH_MARCH = 4'd3;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic        last_date;
	} date_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} cal_t;

	typedef struct packed {
		logic              pair_kind;
		logic [4:0]        first_day;
		logic [3:0]        first_month;
		logic [13:0]       first_year;
		logic [4:0]        second_day;
		logic [3:0]        second_month;
		logic [13:0]       second_year;
		logic [DIST_W-1:0] distance_days;
		logic              too_few;
		logic              last_result;
	} pair_t;

	// Days in the months before the given one, for a common year.
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0, 4'd1: r = 9'd0;
			4'd2:       r = 9'd31;
			4'd3:       r = 9'd59;
			4'd4:       r = 9'd90;
			4'd5:       r = 9'd120;
			4'd6:       r = 9'd151;
			4'd7:       r = 9'd181;
			4'd8:       r = 9'd212;
			4'd9:       r = 9'd243;
			4'd10:      r = 9'd273;
			4'd11:      r = 9'd304;
			4'd12:      r = 9'd334;
			default:    r = 9'd365;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/closest_farthest_date_pair.sv
// ----------------------------------------------------------------------------
// closest_farthest_date_pair
// Loads a set of dates and reports the closest and the farthest pair.
// A stored date keeps busy high through five steps of the shared day number
// unit and one launch state, so no new date is taken until the last is done.
// On a last date with two or more dates held, the pair scan runs one pair per
// cycle through the gap and compare unit. After a read state the two result
// beats follow back to back and the receiver cannot stall them. Reset clears
// the count and sequencers.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_farthest_date_pair
	import cfdp_pkg::*;
#(
	parameter int MAX_DATES = MAX_DATES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire date_t date,
	output logic       busy,
	output logic       result_valid,
	output pair_t      pair
);

	localparam int IW = $clog2(MAX_DATES);
	localparam int CW = $clog2(MAX_DATES + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DNUM   = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_RD0    = 3'd4;
	localparam logic [2:0] ST_OUT0   = 3'd5;
	localparam logic [2:0] ST_OUT1   = 3'd6;

	cal_t date_mem [MAX_DATES];

	logic [2:0]      state_q;
	logic [CW-1:0]   count_q;
	logic            last_q;
	logic            few_q;
	logic            accept;
	logic            full;
	logic            dn_start;
	logic            dn_done;
	logic [DN_W-1:0] dn;
	logic            go;
	logic            srch_done;
	logic [IW-1:0]   close_i, close_j, far_i, far_j;
	logic [DN_W-1:0] close_d, far_d;
	logic [IW-1:0]   ra_f, ra_s;
	cal_t            rd_f_q, rd_s_q;
	cal_t            cal_in;
	logic [DN_W-1:0] out_gap;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q == CW'(MAX_DATES));
	assign dn_start = accept && !full;
	assign go       = (state_q == ST_LAUNCH) && last_q && (count_q >= CW'(2));

	assign cal_in.day   = date.day;
	assign cal_in.month = date.month;
	assign cal_in.year  = date.year;

	cfdp_daynum u_daynum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dn_start),
		.cal    (cal_in),
		.done   (dn_done),
		.dn     (dn)
	);

	cfdp_search #(
		.MAX_DATES (MAX_DATES)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (dn_done),
		.wr_addr (count_q[IW-1:0]),
		.wr_dn   (dn),
		.go      (go),
		.n       (count_q),
		.done    (srch_done),
		.close_i (close_i),
		.close_j (close_j),
		.close_d (close_d),
		.far_i   (far_i),
		.far_j   (far_j),
		.far_d   (far_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			last_q  <= 1'b0;
			few_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= date.last_date;
						if (!full) begin
							state_q <= ST_DNUM;
						end else if (date.last_date) begin
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_DNUM: begin
					if (dn_done) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (count_q < CW'(2)) begin
						few_q   <= 1'b1;
						state_q <= ST_RD0;
					end else begin
						few_q   <= 1'b0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: if (srch_done) state_q <= ST_RD0;
				ST_RD0:    state_q <= ST_OUT0;
				ST_OUT0:   state_q <= ST_OUT1;
				ST_OUT1: begin
					count_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		if (few_q) begin
			ra_f = '0;
			ra_s = '0;
		end else if (state_q == ST_OUT0) begin
			ra_f = far_i;
			ra_s = far_j;
		end else begin
			ra_f = close_i;
			ra_s = close_j;
		end
	end

	always_ff @(posedge clk) begin
		if (dn_start) begin
			date_mem[count_q[IW-1:0]] <= cal_in;
		end
		rd_f_q <= date_mem[ra_f];
		rd_s_q <= date_mem[ra_s];
	end

	always_comb begin
		out_gap = (state_q == ST_OUT1) ? far_d : close_d;
		result_valid       = (state_q == ST_OUT0) || (state_q == ST_OUT1);
		pair.pair_kind     = (state_q == ST_OUT1);
		pair.first_day     = rd_f_q.day;
		pair.first_month   = rd_f_q.month;
		pair.first_year    = rd_f_q.year;
		pair.second_day    = rd_s_q.day;
		pair.second_month  = rd_s_q.month;
		pair.second_year   = rd_s_q.year;
		if (few_q) begin
			pair.distance_days = '0;
		end else if (out_gap > DN_W'(DIST_MAX)) begin
			pair.distance_days = DIST_MAX;
		end else begin
			pair.distance_days = out_gap[DIST_W-1:0];
		end
		pair.too_few     = few_q;
		pair.last_result = (state_q == ST_OUT1);
	end

endmodule

`default_nettype wire

// File: rtl/core/cfdp_daynum.sv
// ----------------------------------------------------------------------------
// cfdp_daynum
// Converts one date to its day number; one shared multiplier serves the divide by 100 and times 365 products.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdp_daynum
	import cfdp_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire cal_t            cal,
	output logic                 done,
	output logic [DN_W-1:0]      dn
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_P100 = 3'd1;
	localparam logic [2:0] PH_Y100 = 3'd2;
	localparam logic [2:0] PH_P365 = 3'd3;
	localparam logic [2:0] PH_SUM1 = 3'd4;
	localparam logic [2:0] PH_SUM2 = 3'd5;

	logic [2:0]        phase_q;
	cal_t              cal_q;
	logic [13:0]       p_q;
	logic [7:0]        qp_q;
	logic [7:0]        qy_q;
	logic [PROD_W-1:0] prod_q;
	logic [DN_W-1:0]   acc_q;
	logic              leap_q;
	logic [13:0]       mul_a;
	logic [12:0]       mul_b;
	logic [13:0]       rem100;
	logic              leap;

	always_comb begin
		mul_a = (phase_q == PH_Y100) ? cal_q.year : p_q;
		mul_b = (phase_q == PH_P365) ? DAYS_YEAR : RECIP_100;
		rem100 = cal_q.year - 14'(15'(qy_q) * CENTURY);
		leap = (rem100 != 14'd0) ? (cal_q.year[1:0] == 2'd0) : (qy_q[1:0] == 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: if (start) phase_q <= PH_P100;
				PH_P100: phase_q <= PH_Y100;
				PH_Y100: phase_q <= PH_P365;
				PH_P365: phase_q <= PH_SUM1;
				PH_SUM1: phase_q <= PH_SUM2;
				PH_SUM2: phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'({13'd0, mul_a} * {14'd0, mul_b});
		if (phase_q == PH_IDLE && start) begin
			cal_q <= cal;
			p_q   <= (cal.year != 14'd0) ? cal.year - 14'd1 : 14'd0;
		end
		if (phase_q == PH_Y100) begin
			qp_q <= prod_q[PROD_W-1:RECIP_SHIFT];
		end
		if (phase_q == PH_P365) begin
			qy_q <= prod_q[PROD_W-1:RECIP_SHIFT];
		end
		if (phase_q == PH_SUM1) begin
			acc_q  <= DN_W'(prod_q) + DN_W'(p_q >> 2) - DN_W'(qp_q) + DN_W'(qp_q >> 2);
			leap_q <= leap;
		end
	end

	assign done = (phase_q == PH_SUM2);
	assign dn = acc_q + DN_W'(cum_days(cal_q.month))
		+ DN_W'(leap_q && (cal_q.month >= MONTH_MARCH)) + DN_W'(cal_q.day);

endmodule

`default_nettype wire

// File: rtl/core/cfdp_search.sv
// ----------------------------------------------------------------------------
// cfdp_search
// Holds the day numbers and scans every pair through one gap and compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdp_search
	import cfdp_pkg::*;
#(
	parameter int MAX_DATES = MAX_DATES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [$clog2(MAX_DATES)-1:0]     wr_addr,
	input  wire logic [DN_W-1:0]                  wr_dn,
	input  wire logic                             go,
	input  wire logic [$clog2(MAX_DATES+1)-1:0]   n,
	output logic                                  done,
	output logic [$clog2(MAX_DATES)-1:0]          close_i,
	output logic [$clog2(MAX_DATES)-1:0]          close_j,
	output logic [DN_W-1:0]                       close_d,
	output logic [$clog2(MAX_DATES)-1:0]          far_i,
	output logic [$clog2(MAX_DATES)-1:0]          far_j,
	output logic [DN_W-1:0]                       far_d
);

	localparam int IW = $clog2(MAX_DATES);
	localparam int CW = $clog2(MAX_DATES + 1);
	localparam logic [IW-1:0] ONE = IW'(1);

	localparam logic [1:0] SS_IDLE  = 2'd0;
	localparam logic [1:0] SS_RUN   = 2'd1;
	localparam logic [1:0] SS_DRAIN = 2'd2;

	logic [DN_W-1:0] dn_mem [MAX_DATES];

	logic [1:0]      state_q;
	logic [IW-1:0]   i_q, j_q, last_q;
	logic            v_s1, v_s2;
	logic [DN_W-1:0] a_s1, b_s1, g_s2;
	logic [IW-1:0]   pi_s1, pj_s1, pi_s2, pj_s2;
	logic            first;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dn_mem[wr_addr] <= wr_dn;
		end
		a_s1 <= dn_mem[i_q];
		b_s1 <= dn_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= (state_q == SS_RUN);
			v_s2 <= v_s1;
			case (state_q)
				SS_IDLE: if (go) state_q <= SS_RUN;
				SS_RUN: begin
					if (j_q == last_q && i_q == last_q - ONE) state_q <= SS_DRAIN;
				end
				SS_DRAIN: if (!v_s1 && !v_s2) state_q <= SS_IDLE;
				default: state_q <= SS_IDLE;
			endcase
		end
	end

	assign first = (pi_s2 == '0) && (pj_s2 == ONE);

	always_ff @(posedge clk) begin
		if (state_q == SS_IDLE && go) begin
			i_q    <= '0;
			j_q    <= ONE;
			last_q <= IW'(n - CW'(1));
		end else if (state_q == SS_RUN) begin
			if (j_q == last_q) begin
				i_q <= i_q + ONE;
				j_q <= i_q + ONE + ONE;
			end else begin
				j_q <= j_q + ONE;
			end
		end
		pi_s1 <= i_q;
		pj_s1 <= j_q;
		pi_s2 <= pi_s1;
		pj_s2 <= pj_s1;
		g_s2  <= (a_s1 > b_s1) ? a_s1 - b_s1 : b_s1 - a_s1;
		if (v_s2) begin
			if (first || g_s2 < close_d) begin
				close_d <= g_s2;
				close_i <= pi_s2;
				close_j <= pj_s2;
			end
			if (first || g_s2 > far_d) begin
				far_d <= g_s2;
				far_i <= pi_s2;
				far_j <= pj_s2;
			end
		end
	end

	assign done = (state_q == SS_DRAIN) && !v_s1 && !v_s2;

endmodule

`default_nettype wire

// File: rtl/core/cfdp_checker.sv
// ----------------------------------------------------------------------------
// cfdp_checker
// Port-level checks on the result beats of the date pair block.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdp_checker
	import cfdp_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  start,
	input wire logic  busy,
	input wire logic  result_valid,
	input wire pair_t pair
);

	// The closest pair beat is always followed at once by the farthest pair beat.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pair.last_result |=> result_valid && pair.last_result)
		else $error("closest beat not followed by farthest beat");

	a_end_of_set: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pair.last_result |=> !result_valid && !busy)
		else $error("block not idle after the final beat");

	a_kind_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pair.pair_kind == pair.last_result) && busy)
		else $error("result kind disagrees with final marker");

	// A single date reports itself in both slots at zero distance.
	a_too_few: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pair.too_few |-> pair.distance_days == '0
			&& pair.first_day == pair.second_day
			&& pair.first_month == pair.second_month
			&& pair.first_year == pair.second_year)
		else $error("single date beat is inconsistent");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && busy && !result_valid |=> !result_valid || $past(busy))
		else $error("result beat without a busy period");

endmodule

bind closest_farthest_date_pair cfdp_checker u_cfdp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.pair         (pair)
);

`default_nettype wire
